FILE: design/lccs_pkg.sv
// Package: shared constants, types and state codes for the window statistics block.
package lccs_pkg;

  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;
  localparam int unsigned MaxRadiusDef = 3;
  localparam int unsigned PixelBitsDef = 16;

  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 9;
  localparam logic [CfgIdxBits-1:0] CfgRadius = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgWidth  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgHeight = 2'd2;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam int unsigned InBits  = 56;
  localparam int unsigned OutBits = 176;

  // Sequencer states of a query.
  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StMul,
    StDiv,
    StOut
  } state_e;

endpackage

FILE: design/local_cross_correlation_stats_top.sv
// Top level: pixel stores and the sequencer that accumulates and divides window statistics.
//
// Usage. The slave stream (s_axis_*) carries load and query transfers with the
// command in tuser. The master stream (m_axis_*) carries one result per query
// and none per load, with has_data in tuser. The configuration port writes
// radius, image width and image height; the user is to do so only while the
// block is idle, which the block itself does not enforce. A load writes the
// three pixel stores at the pixel when it lies inside the image. A query walks
// its window one pixel a cycle through the store read port and then reads the
// centre. It then forms the three product differences and divides five
// dividends by the count with a bit-serial restoring divider. An empty window
// skips the products and the division, and a query outside the image goes
// straight to the output. Only one item is in work at a time. The input is not
// ready meanwhile and is ready again as the result appears.
// Reset returns the registers to radius 2, width 256, height 256, empties the
// output register and idles the sequencer. Store contents are undefined until
// loaded. A stalled receiver holds the result in the output register, and a
// further query waits behind it.
module local_cross_correlation_stats_top #(
  parameter int unsigned MAX_WIDTH  = lccs_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = lccs_pkg::MaxHeightDef,
  parameter int unsigned MAX_RADIUS = lccs_pkg::MaxRadiusDef,
  parameter int unsigned PIXEL_BITS = lccs_pkg::PixelBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lccs_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [lccs_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // cmd[0]
  input  logic                             s_axis_tuser,
  // pos_x[7:0] pos_y[15:8] fixed_value[31:16] moving_value[47:32] mask_ok[48]
  input  logic [lccs_pkg::InBits-1:0]      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // has_data[0]
  output logic                             m_axis_tuser,
  // window_count[5:0] fixed_centered[27:6] moving_centered[49:28]
  // cross_sum[90:50] fixed_var_sum[130:91] moving_var_sum[170:131]
  output logic [lccs_pkg::OutBits-1:0]     m_axis_tdata
);

  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = 1 << AW;
  localparam int unsigned RW    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned WSide = 2 * MAX_RADIUS + 1;
  localparam int unsigned NW    = $clog2(WSide * WSide + 1);
  // Signed coordinate width (room for -MAX_RADIUS and MAX+MAX_RADIUS).
  localparam int unsigned CW    = ((XW > YW) ? XW : YW) + 3;
  localparam int unsigned SW    = PIXEL_BITS + NW;       // linear sums
  localparam int unsigned QW    = 2 * PIXEL_BITS + NW;   // square sums
  localparam int unsigned PW    = QW + NW + 2;           // products (signed)
  localparam int unsigned DW    = PW + 4;                // dividend magnitude
  localparam int unsigned DCW   = $clog2(DW + 1);

  // ---------------------------------------------------------------- config
  logic [1:0] radius_q;
  logic [8:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 2'd2;
      width_q  <= 9'd256;
      height_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lccs_pkg::CfgRadius: radius_q <= cfg_data_i[1:0];
        lccs_pkg::CfgWidth:  width_q  <= cfg_data_i;
        lccs_pkg::CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [12:0] eff_w, eff_h;
  logic [RW:0] eff_r;
  always_comb begin
    eff_w = (13'(width_q) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_q);
    eff_h = (13'(height_q) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(height_q);
    eff_r = ((RW+1)'(radius_q) > (RW+1)'(MAX_RADIUS)) ? (RW+1)'(MAX_RADIUS)
                                                      : (RW+1)'(radius_q);
  end

  // ---------------------------------------------------------------- input fields
  logic             in_cmd, in_mask;
  logic [7:0]       in_x, in_y;
  logic [15:0]      in_fv, in_mv;
  assign in_cmd  = s_axis_tuser;
  assign in_x    = s_axis_tdata[7:0];
  assign in_y    = s_axis_tdata[15:8];
  assign in_fv   = s_axis_tdata[31:16];
  assign in_mv   = s_axis_tdata[47:32];
  assign in_mask = s_axis_tdata[48];

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- stores
  logic [PIXEL_BITS-1:0] fmem [Depth];
  logic [PIXEL_BITS-1:0] mmem [Depth];
  logic                  kmem [Depth];
  logic [PIXEL_BITS-1:0] rd_f_q, rd_m_q;
  logic                  rd_k_q;
  logic                  we;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic                  in_img;

  assign in_img  = (13'(in_x) < eff_w) && (13'(in_y) < eff_h);
  assign we      = in_fire && (in_cmd == lccs_pkg::CmdLoad) && in_img;
  assign wr_addr = {YW'(in_y), XW'(in_x)};

  always_ff @(posedge clk_i) begin
    if (we) begin
      fmem[wr_addr] <= in_fv[PIXEL_BITS-1:0];
      mmem[wr_addr] <= in_mv[PIXEL_BITS-1:0];
      kmem[wr_addr] <= in_mask;
    end
    rd_f_q <= fmem[rd_addr];
    rd_m_q <= mmem[rd_addr];
    rd_k_q <= kmem[rd_addr];
  end

  // ---------------------------------------------------------------- sequencer
  lccs_pkg::state_e state_q, state_d;

  logic [7:0]          cx_q, cy_q;
  logic signed [CW-1:0] dx_q, dy_q;        // window offsets
  logic                centre_q, centre_rd_q; // final read is the centre
  logic                rd_v_q, rd_inwin_q;
  logic [NW-1:0]       n_q;
  logic [SW-1:0]       sa_q, sb_q;
  logic [QW-1:0]       saa_q, sbb_q, sab_q;
  logic [PIXEL_BITS-1:0] a0_q, b0_q;
  logic [2:0]          mstep_q;            // multiply/divide step
  logic signed [PW-1:0] prod_q [3];        // dividends before scale
  logic [DCW-1:0]      dcnt_q;
  logic [DW-1:0]       rem_q, quo_q;
  logic signed [DW:0]  quo_s [5];
  logic                qvalid_q;           // query inside image
  logic                scan_done;

  // Current read coordinate and bound test.
  logic signed [CW-1:0] rx, ry;
  logic                 rd_in;
  assign rx = CW'(cx_q) + dx_q;
  assign ry = CW'(cy_q) + dy_q;
  assign rd_in = centre_q ? 1'b1 :
                 (rx >= 0) && (ry >= 0) && (rx < CW'(eff_w)) && (ry < CW'(eff_h));
  assign rd_addr = centre_q ? {YW'(cy_q), XW'(cx_q)} : {YW'(ry), XW'(rx)};

  logic signed [CW-1:0] rs;
  assign rs = CW'(eff_r);
  assign scan_done = centre_q;

  // Form one product difference per step: count times square sum less sum product.
  logic [QW-1:0]        mul_q;
  logic [SW-1:0]        mul_s1, mul_s2;
  logic [NW+QW-1:0]     prod_n;
  logic [2*SW-1:0]      prod_s;
  logic signed [PW-1:0] prod_diff;
  always_comb begin
    case (mstep_q)
      3'd0: begin mul_q = sab_q; mul_s1 = sa_q; mul_s2 = sb_q; end
      3'd1: begin mul_q = saa_q; mul_s1 = sa_q; mul_s2 = sa_q; end
      default: begin mul_q = sbb_q; mul_s1 = sb_q; mul_s2 = sb_q; end
    endcase
    prod_n    = n_q * mul_q;
    prod_s    = mul_s1 * mul_s2;
    prod_diff = PW'(prod_n) - PW'(prod_s);
  end

  // Divider operand: dividend index follows the step.
  logic signed [PW-1:0] dvd;
  logic                 dneg;
  logic [DW-1:0]        dmag;
  logic [DW:0]          trial;
  always_comb begin
    case (mstep_q)
      3'd0: dvd = PW'(sa_q);
      3'd1: dvd = PW'(sb_q);
      3'd2: dvd = prod_q[0];
      3'd3: dvd = prod_q[1];
      default: dvd = prod_q[2];
    endcase
    dneg  = dvd[PW-1];
    dmag  = dneg ? DW'(-dvd) << 4 : DW'(dvd) << 4;
    trial = {rem_q, quo_q[DW-1]} - (DW+1)'(n_q);
  end

  logic out_v_q, out_v_d;
  logic out_user_q, out_user_d;
  logic [lccs_pkg::OutBits-1:0] out_q, out_d;
  logic out_free;
  assign out_free = !out_v_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lccs_pkg::StIdle:
        if (in_fire && in_cmd == lccs_pkg::CmdQuery) begin
          state_d = in_img ? lccs_pkg::StScan : lccs_pkg::StOut;
        end
      lccs_pkg::StScan:  if (scan_done) state_d = lccs_pkg::StDrain;
      lccs_pkg::StDrain: state_d = (n_q == '0) ? lccs_pkg::StOut : lccs_pkg::StMul;
      lccs_pkg::StMul:   if (mstep_q == 3'd2) state_d = lccs_pkg::StDiv;
      lccs_pkg::StDiv:
        if (mstep_q == 3'd4 && dcnt_q == DCW'(DW + 1)) state_d = lccs_pkg::StOut;
      lccs_pkg::StOut:   if (out_free) state_d = lccs_pkg::StIdle;
      default: state_d = lccs_pkg::StIdle;
    endcase
  end

  // Outputs of the sequencer.
  assign s_axis_tready = (state_q == lccs_pkg::StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= lccs_pkg::StIdle;
    else         state_q <= state_d;
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rd_v_q      <= (state_q == lccs_pkg::StScan);
    rd_inwin_q  <= rd_in;
    centre_rd_q <= centre_q && (state_q == lccs_pkg::StScan);
    case (state_q)
      lccs_pkg::StIdle: begin
        cx_q <= in_x; cy_q <= in_y;
        dx_q <= -CW'(eff_r); dy_q <= -CW'(eff_r);
        centre_q <= 1'b0; qvalid_q <= in_img;
        n_q <= '0; sa_q <= '0; sb_q <= '0;
        saa_q <= '0; sbb_q <= '0; sab_q <= '0;
        mstep_q <= '0;
      end
      lccs_pkg::StScan: begin
        // Advance through the window row by row, then read the centre.
        if (!centre_q) begin
          if (dx_q == rs) begin
            dx_q <= -rs;
            if (dy_q == rs) centre_q <= 1'b1;
            else dy_q <= dy_q + 1'b1;
          end else dx_q <= dx_q + 1'b1;
        end
      end
      lccs_pkg::StMul: begin
        prod_q[mstep_q[1:0]] <= prod_diff;
        if (mstep_q == 3'd2) begin
          mstep_q <= '0; dcnt_q <= '0;
        end else mstep_q <= mstep_q + 1'b1;
      end
      lccs_pkg::StDiv: begin
        // Restoring division, one quotient bit a cycle.
        if (dcnt_q == '0) begin
          rem_q <= '0; quo_q <= dmag; dcnt_q <= dcnt_q + 1'b1;
        end else if (dcnt_q == DCW'(DW + 1)) begin
          quo_s[mstep_q] <= dneg ? -(DW+1)'(quo_q) : (DW+1)'(quo_q);
          dcnt_q <= '0; mstep_q <= mstep_q + 1'b1;
        end else begin
          if (!trial[DW]) begin
            rem_q <= trial[DW-1:0];
            quo_q <= {quo_q[DW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
            quo_q <= {quo_q[DW-2:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 1'b1;
        end
      end
      default: ;
    endcase
    // Accumulate the data returned by the store.
    if (rd_v_q) begin
      if (centre_rd_q) begin
        a0_q <= rd_f_q; b0_q <= rd_m_q;
      end else if (rd_inwin_q && rd_k_q) begin
        n_q   <= n_q + 1'b1;
        sa_q  <= sa_q + SW'(rd_f_q);
        sb_q  <= sb_q + SW'(rd_m_q);
        saa_q <= saa_q + QW'(rd_f_q * rd_f_q);
        sbb_q <= sbb_q + QW'(rd_m_q * rd_m_q);
        sab_q <= sab_q + QW'(rd_f_q * rd_m_q);
      end
    end
  end

  // Result fields.
  logic has;
  assign has = qvalid_q && (n_q != '0);

  always_comb begin
    out_d      = '0;
    out_user_d = 1'b0;
    if (has) begin
      out_user_d     = 1'b1;
      out_d[5:0]     = 6'(n_q);
      out_d[27:6]    = 22'(((DW+1)'(a0_q) << 4) - quo_s[0]);
      out_d[49:28]   = 22'(((DW+1)'(b0_q) << 4) - quo_s[1]);
      out_d[90:50]   = 41'(quo_s[2]);
      out_d[130:91]  = 40'(quo_s[3]);
      out_d[170:131] = 40'(quo_s[4]);
    end
  end

  // Result valid: drop on transfer, set when a new result is loaded.
  always_comb begin
    out_v_d = out_v_q;
    if (m_axis_tready) out_v_d = 1'b0;
    if (state_q == lccs_pkg::StOut && out_free) out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (state_q == lccs_pkg::StOut && out_free) begin
      out_q      <= out_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: design/lccs_checker.sv
// Checker: port-level properties of the window statistics block, bound to the top level.
module lccs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         s_axis_tuser,
  input logic [lccs_pkg::InBits-1:0]  s_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic                         m_axis_tuser,
  input logic [lccs_pkg::OutBits-1:0] m_axis_tdata
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A result without data carries zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("empty result has nonzero fields");

  // A result with data has a nonzero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[5:0] != 6'd0)
    else $error("result with data has zero count");

  // A query transfer makes the input busy next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == lccs_pkg::CmdQuery)
      |=> !s_axis_tready)
    else $error("query did not stall input");

endmodule

bind local_cross_correlation_stats_top lccs_checker u_lccs_checker (.*);
